### sv/bcad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_pkg
// Shared types and constants for the BC2/BC3 alpha block decoder.
// ----------------------------------------------------------------------------
package bcad_pkg;

  localparam int NUM_TEXELS  = 16;
  localparam int HALF_TEXELS = NUM_TEXELS / 2;
  localparam int PAL_ENTRIES = 8;
  localparam int ALPHA_W     = 8;
  localparam int NIBBLE_W    = 4;
  localparam int INDEX_W     = 3;
  localparam int BLOCK_W     = 64;
  localparam int INDEX_BASE  = 16;

  // Reciprocals for truncating division: q = (x * RECIP) >> RECIP_SHIFT.
  // Exact for x <= 7*255 (divide by 7) and x <= 5*255 (divide by 5).
  localparam int RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP7 = 14'd9363;
  localparam logic [13:0] RECIP5 = 14'd13108;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_BC2    = 2'd0;
  localparam func_t FUNC_BC3    = 2'd1;
  localparam func_t FUNC_OPAQUE = 2'd2;

  typedef logic [ALPHA_W-1:0]                alpha_t;
  typedef alpha_t [PAL_ENTRIES-1:0]          pal_t;
  typedef logic [BLOCK_W-1:0]                block_t;

  localparam alpha_t ALPHA_OPAQUE = 8'hFF;
  localparam alpha_t ALPHA_CLEAR  = 8'h00;

  // Per-texel selection inputs handed to one lane.
  typedef struct packed {
    func_t                func;
    logic [NIBBLE_W-1:0]  nibble;
    logic [INDEX_W-1:0]   index;
  } lane_in_t;

endpackage

### sv/bcad_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_palette
// Two-stage BC3 palette builder: weighted endpoint sums, then reciprocal divide.
// ----------------------------------------------------------------------------
module bcad_palette (
  input  logic             clk,
  input  logic             adv,
  input  bcad_pkg::block_t block_bits,
  output bcad_pkg::pal_t   pal
);
  import bcad_pkg::*;

  logic [7:0]  e0, e1;
  logic [10:0] sum7_nxt [1:6];
  logic [10:0] sum7_r   [1:6];
  logic [10:0] sum5_nxt [1:4];
  logic [10:0] sum5_r   [1:4];
  logic        gt_r;
  alpha_t      e0_r, e1_r;
  pal_t        pal_nxt, pal_r;

  assign e0 = block_bits[7:0];
  assign e1 = block_bits[15:8];

  // Stage A: weighted sums for both interpolation modes.
  always_comb begin
    for (int i = 1; i <= 6; i++) begin
      sum7_nxt[i] = 11'(e0) * 11'(7 - i) + 11'(e1) * 11'(i);
    end
    for (int i = 1; i <= 4; i++) begin
      sum5_nxt[i] = 11'(e0) * 11'(5 - i) + 11'(e1) * 11'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum7_r <= sum7_nxt;
      sum5_r <= sum5_nxt;
      gt_r   <= e0 > e1;
      e0_r   <= e0;
      e1_r   <= e1;
    end
  end

  // Stage B: divide by 7 or 5 via reciprocal multiply, then pick the mode.
  always_comb begin
    logic [24:0] p7;
    logic [24:0] p5;
    pal_nxt    = '0;
    pal_nxt[0] = e0_r;
    pal_nxt[1] = e1_r;
    for (int i = 1; i <= 6; i++) begin
      p7 = sum7_r[i] * RECIP7;
      p5 = (i <= 4) ? sum5_r[i] * RECIP5 : '0;
      if (gt_r) begin
        pal_nxt[i + 1] = p7[RECIP_SHIFT +: ALPHA_W];
      end else if (i <= 4) begin
        pal_nxt[i + 1] = p5[RECIP_SHIFT +: ALPHA_W];
      end else if (i == 5) begin
        pal_nxt[i + 1] = ALPHA_CLEAR;
      end else begin
        pal_nxt[i + 1] = ALPHA_OPAQUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pal_r <= pal_nxt;
    end
  end

  assign pal = pal_r;

endmodule

### sv/bcad_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_lane
// One texel lane: expand a BC2 nibble, look up the BC3 palette, or go opaque.
// ----------------------------------------------------------------------------
module bcad_lane (
  input  bcad_pkg::lane_in_t lane_in,
  input  bcad_pkg::pal_t     pal,
  output bcad_pkg::alpha_t   alpha
);
  import bcad_pkg::*;

  always_comb begin
    unique case (lane_in.func)
      FUNC_BC2: alpha = {lane_in.nibble, lane_in.nibble};  // nibble * 17
      FUNC_BC3: alpha = pal[lane_in.index];
      default:  alpha = ALPHA_OPAQUE;
    endcase
  end

endmodule

### sv/bc_block_alpha_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_block_alpha_decoder_top
// BC2/BC3 alpha block decoder: one 64-bit block in, sixteen 8-bit alphas out.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_func, in_block_bits | block in
//  out     | out_valid, out_stall, out_alphas_*         | alphas out
//
// Throughput is one block per cycle unless a result in the output register is
// held by out_stall. The path is input register, palette sum stage, palette
// divide stage, then sixteen select lanes merged into the output register.
// The whole pipeline advances together whenever the output register is empty
// or its transaction completes; in_stall is high only while a result sits in
// the output register under out_stall.
// Reset (rst_n low, synchronous) clears every stage valid; data regs keep
// whatever they held and are ignored until refilled.
// ----------------------------------------------------------------------------
module bc_block_alpha_decoder_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bcad_pkg::func_t  in_func,
  input  bcad_pkg::block_t in_block_bits,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_alphas_first_half,
  output logic [63:0]      out_alphas_second_half
);
  import bcad_pkg::*;

  // Pipeline advance: output slot free or being drained this cycle.
  logic adv;

  // Stage valids (control, reset) and their payloads (no reset).
  logic   v1_r, v2_r, v3_r, out_valid_r;
  func_t  func1_r, func2_r, func3_r;
  block_t bits1_r, bits2_r, bits3_r;
  pal_t   pal;

  lane_in_t lane_in [NUM_TEXELS];
  alpha_t   alpha   [NUM_TEXELS];
  logic [63:0] first_nxt, second_nxt, first_r, second_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Advance the valid chain; a bubble moves through like a transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Carry the selector and raw block alongside the palette stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= in_func;
      bits1_r <= in_block_bits;
      func2_r <= func1_r;
      bits2_r <= bits1_r;
      func3_r <= func2_r;
      bits3_r <= bits2_r;
    end
  end

  // Palette is ready two stages after the input register, aligned with stage 3.
  bcad_palette u_palette (
    .clk        (clk),
    .adv        (adv),
    .block_bits (bits1_r),
    .pal        (pal)
  );

  // Sixteen lanes work side by side on the texels of the stage-3 block.
  for (genvar t = 0; t < NUM_TEXELS; t++) begin : g_lane
    assign lane_in[t].func   = func3_r;
    assign lane_in[t].nibble = bits3_r[NIBBLE_W*t +: NIBBLE_W];
    assign lane_in[t].index  = bits3_r[INDEX_BASE + INDEX_W*t +: INDEX_W];

    bcad_lane u_lane (
      .lane_in (lane_in[t]),
      .pal     (pal),
      .alpha   (alpha[t])
    );
  end

  // Merge: pack lane results into the two result halves, row order.
  always_comb begin
    for (int t = 0; t < HALF_TEXELS; t++) begin
      first_nxt[ALPHA_W*t +: ALPHA_W]  = alpha[t];
      second_nxt[ALPHA_W*t +: ALPHA_W] = alpha[t + HALF_TEXELS];
    end
  end

  // Output register: hold while stalled, load on advance.
  always_ff @(posedge clk) begin
    if (adv) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_alphas_first_half  = first_r;
  assign out_alphas_second_half = second_r;

endmodule

### sv/bcad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_checker
// Port-level checks for the alpha block decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bcad_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [63:0]      out_alphas_first_half,
  input logic [63:0]      out_alphas_second_half
);
  import bcad_pkg::*;

  // Input backpressure only comes from a result blocked at the output.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  // A free output never backs up the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("in_stall with output free");

  // Reset drops any result in flight.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // A blocked result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_alphas_first_half)
                                  && $stable(out_alphas_second_half)))
    else $error("blocked result changed");

endmodule

bind bc_block_alpha_decoder_top bcad_checker u_bcad_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_alphas_first_half  (out_alphas_first_half),
  .out_alphas_second_half (out_alphas_second_half)
);
